/* sv/bssc_pkg.sv */
// ----------------------------------------------------------------------------
// bssc_pkg
// Shared types, constants and commutation tables for the six-step commutator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bssc_pkg;

  localparam int OFFSET_BITS   = 12;
  localparam int TURN_IN_BITS  = 14;
  localparam int TURN_BITS     = 16;
  localparam int MODE_BITS     = 3;
  localparam int USER_BITS     = 8;
  localparam int PHASES        = 3;

  localparam logic [OFFSET_BITS-1:0] OFFSET_RESET = 12'd682;
  localparam logic [15:0]            HOLD_STOPPED = 16'hFFFF;
  localparam logic [5:0]             ALL_SEEN     = 6'h3F;
  localparam logic [2:0]             ALL_PHASES   = 3'b111;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_TICK       = 3'd0,
    MODE_SET_DUTY   = 3'd1,
    MODE_SET_DIR    = 3'd2,
    MODE_START_STEP = 3'd3,
    MODE_START_CONT = 3'd4,
    MODE_STOP       = 3'd5
  } mode_t;

  typedef struct packed {
    logic [2:0] slot;
    logic [5:0] gates;
    logic [2:0] enable;
    logic [1:0] hi;
    logic [1:0] lo;
  } slot_info_t;

  function automatic slot_info_t slot_lookup(input logic [2:0] slot);
    slot_info_t s;
    s.slot = slot;
    case (slot)
      3'd0: begin s.gates = 6'h18; s.enable = 3'd6; s.hi = 2'd1; s.lo = 2'd2; end
      3'd1: begin s.gates = 6'h09; s.enable = 3'd3; s.hi = 2'd1; s.lo = 2'd0; end
      3'd2: begin s.gates = 6'h21; s.enable = 3'd5; s.hi = 2'd2; s.lo = 2'd0; end
      3'd3: begin s.gates = 6'h24; s.enable = 3'd6; s.hi = 2'd2; s.lo = 2'd1; end
      3'd4: begin s.gates = 6'h06; s.enable = 3'd3; s.hi = 2'd0; s.lo = 2'd1; end
      3'd5: begin s.gates = 6'h12; s.enable = 3'd5; s.hi = 2'd0; s.lo = 2'd2; end
      default: begin s.gates = 6'h00; s.enable = 3'd0; s.hi = 2'd0; s.lo = 2'd0; end
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

/* sv/bldc_six_step_commutator_unit.sv */
// ----------------------------------------------------------------------------
// bldc_six_step_commutator_unit
// Six-step BLDC commutation from a resolver angle, with run control commands.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  in_*      in   tvalid/tready        tdata: command fields, tuser: mode, duty flag
//  out_*     out  tvalid/tready        tdata: phase drive result
//  cfg_*     in   wr_en                wr_data: rotor offset
//
//  One transaction per cycle sustained while out_tready is high; results pass
//  through the input and result registers around the decode and state logic.
//  Synchronous active-low reset puts the drive in the held-stopped state.
//  A stalled output holds its result; the input register still takes one more
//  transaction, then in_tready drops until the output moves.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bldc_six_step_commutator_unit
  import bssc_pkg::*;
#(
  parameter int POSITION_BITS = 12,
  parameter int DUTY_BITS     = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_tvalid,
  output logic                         in_tready,
  // rotor_position, direction, turn_count, duty, zero fill
  input  wire logic [((POSITION_BITS + 1 + TURN_IN_BITS + DUTY_BITS + 7) / 8) * 8 - 1:0] in_tdata,
  // mode[2:0], duty_valid[3], zero fill
  input  wire logic [USER_BITS-1:0]    in_tuser,
  output logic                         out_tvalid,
  input  wire logic                    out_tready,
  // phase_enable, duty_a, duty_b, duty_c, gate_pattern, sector, turns_left,
  // halted, zero fill
  output logic [((3 + 3 * DUTY_BITS + 6 + 3 + TURN_BITS + 1 + 7) / 8) * 8 - 1:0] out_tdata,
  input  wire logic                    cfg_wr_en,
  input  wire logic [OFFSET_BITS-1:0]  cfg_wr_data
);

  localparam int IN_USED  = POSITION_BITS + 1 + TURN_IN_BITS + DUTY_BITS;
  localparam int OUT_USED = 3 + 3 * DUTY_BITS + 6 + 3 + TURN_BITS + 1;
  localparam int OUT_W    = ((OUT_USED + 7) / 8) * 8;
  localparam int S1_W     = IN_USED + MODE_BITS + 1;

  localparam int DIR_LSB  = POSITION_BITS;
  localparam int TURN_LSB = POSITION_BITS + 1;
  localparam int DUTY_LSB = TURN_LSB + TURN_IN_BITS;

  logic [OFFSET_BITS-1:0]   offset_r;
  logic [S1_W-1:0]          in_word;
  logic [S1_W-1:0]          s1_word;
  logic                     s1_valid;
  logic                     s1_ready;
  logic [POSITION_BITS-1:0] s1_pos;
  logic                     s1_dir;
  logic [TURN_IN_BITS-1:0]  s1_turns;
  logic [DUTY_BITS-1:0]     s1_duty;
  logic [MODE_BITS-1:0]     s1_mode;
  logic                     s1_dvalid;
  logic                     reverse;
  slot_info_t               info;

  logic [2:0]               r_enable;
  logic [DUTY_BITS-1:0]     r_duty_a;
  logic [DUTY_BITS-1:0]     r_duty_b;
  logic [DUTY_BITS-1:0]     r_duty_c;
  logic [5:0]               r_gates;
  logic [2:0]               r_sector;
  logic [TURN_BITS-1:0]     r_turns;
  logic                     r_halted;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= OFFSET_RESET;
    end else if (cfg_wr_en) begin
      offset_r <= cfg_wr_data;
    end
  end

  assign in_word = {in_tuser[MODE_BITS], in_tuser[MODE_BITS-1:0], in_tdata[IN_USED-1:0]};

  bssc_in_stage #(
    .WIDTH (S1_W)
  ) u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_data  (in_word),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_data  (s1_word)
  );

  assign s1_pos    = s1_word[POSITION_BITS-1:0];
  assign s1_dir    = s1_word[DIR_LSB];
  assign s1_turns  = s1_word[TURN_LSB +: TURN_IN_BITS];
  assign s1_duty   = s1_word[DUTY_LSB +: DUTY_BITS];
  assign s1_mode   = s1_word[IN_USED +: MODE_BITS];
  assign s1_dvalid = s1_word[S1_W-1];

  bssc_sector_decode #(
    .POSITION_BITS (POSITION_BITS)
  ) u_sector_decode (
    .rotor_position (s1_pos),
    .rotor_offset   (offset_r),
    .reverse        (reverse),
    .info           (info)
  );

  bssc_core #(
    .DUTY_BITS (DUTY_BITS)
  ) u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_valid         (s1_valid),
    .s1_ready         (s1_ready),
    .mode             (s1_mode),
    .direction        (s1_dir),
    .turn_count       (s1_turns),
    .duty_valid       (s1_dvalid),
    .duty             (s1_duty),
    .info             (info),
    .reverse          (reverse),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_phase_enable (r_enable),
    .out_duty_a       (r_duty_a),
    .out_duty_b       (r_duty_b),
    .out_duty_c       (r_duty_c),
    .out_gate_pattern (r_gates),
    .out_sector       (r_sector),
    .out_turns_left   (r_turns),
    .out_halted       (r_halted)
  );

  assign out_tdata = OUT_W'({r_halted, r_turns, r_sector, r_gates,
                             r_duty_c, r_duty_b, r_duty_a, r_enable});

endmodule

`default_nettype wire

/* sv/bssc_in_stage.sv */
// ----------------------------------------------------------------------------
// bssc_in_stage
// Input register: holds one accepted transaction until the core takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bssc_in_stage #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [WIDTH-1:0] in_data,
  output logic                  s1_valid,
  input  wire logic             s1_ready,
  output logic [WIDTH-1:0]      s1_data
);

  logic             valid_r;
  logic             valid_nxt;
  logic [WIDTH-1:0] data_r;

  assign in_ready = !valid_r || s1_ready;
  assign s1_valid = valid_r;
  assign s1_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

/* sv/bssc_sector_decode.sv */
// ----------------------------------------------------------------------------
// bssc_sector_decode
// Angle plus offset to commutation slot, with direction mapping and table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bssc_sector_decode
  import bssc_pkg::*;
#(
  parameter int POSITION_BITS = 12
) (
  input  wire logic [POSITION_BITS-1:0] rotor_position,
  input  wire logic [OFFSET_BITS-1:0]   rotor_offset,
  input  wire logic                     reverse,
  output slot_info_t                    info
);

  localparam int SPAN = ((1 << POSITION_BITS) + 5) / 6;

  logic [POSITION_BITS-1:0] wrapped;
  logic [2:0]               quot;
  logic [2:0]               slot;

  assign wrapped = rotor_position + POSITION_BITS'(rotor_offset);

  always_comb begin
    quot = 3'd0;
    for (int k = 1; k < 6; k++) begin
      if (wrapped >= POSITION_BITS'(SPAN * k)) begin
        quot = 3'(k);
      end
    end
  end

  always_comb begin
    case ({reverse, quot})
      4'b0_000: slot = 3'd1;
      4'b0_001: slot = 3'd2;
      4'b0_010: slot = 3'd3;
      4'b0_011: slot = 3'd4;
      4'b0_100: slot = 3'd5;
      4'b0_101: slot = 3'd0;
      4'b1_000: slot = 3'd4;
      4'b1_001: slot = 3'd5;
      4'b1_010: slot = 3'd0;
      4'b1_011: slot = 3'd1;
      4'b1_100: slot = 3'd2;
      4'b1_101: slot = 3'd3;
      default:  slot = 3'd0;
    endcase
  end

  assign info = slot_lookup(slot);

endmodule

`default_nettype wire

/* sv/bssc_core.sv */
// ----------------------------------------------------------------------------
// bssc_core
// Drive state, command handling and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bssc_core
  import bssc_pkg::*;
#(
  parameter int DUTY_BITS = 16
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    s1_valid,
  output logic                         s1_ready,
  input  wire logic [MODE_BITS-1:0]    mode,
  input  wire logic                    direction,
  input  wire logic [TURN_IN_BITS-1:0] turn_count,
  input  wire logic                    duty_valid,
  input  wire logic [DUTY_BITS-1:0]    duty,
  input  slot_info_t                   info,
  output logic                         reverse,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   out_phase_enable,
  output logic [DUTY_BITS-1:0]         out_duty_a,
  output logic [DUTY_BITS-1:0]         out_duty_b,
  output logic [DUTY_BITS-1:0]         out_duty_c,
  output logic [5:0]                   out_gate_pattern,
  output logic [2:0]                   out_sector,
  output logic [TURN_BITS-1:0]         out_turns_left,
  output logic                         out_halted
);

  logic [15:0]          inhibit_r,  inhibit_nxt;
  logic [TURN_BITS-1:0] turns_r,    turns_nxt;
  logic                 stepped_r,  stepped_nxt;
  logic                 reverse_r,  reverse_nxt;
  logic [DUTY_BITS-1:0] drive_r,    drive_nxt;
  logic [5:0]           seen_r,     seen_nxt;
  logic [2:0]           phase_on_r, phase_on_nxt;
  logic [DUTY_BITS-1:0] pduty_r   [PHASES];
  logic [DUTY_BITS-1:0] pduty_nxt [PHASES];
  logic                 valid_r,    valid_nxt;
  logic [5:0]           gates;
  logic [2:0]           slot;
  logic [5:0]           seen_set;
  logic [TURN_BITS-1:0] turns_dec;
  logic                 advance;

  logic [2:0]           res_enable_r;
  logic [DUTY_BITS-1:0] res_duty_r [PHASES];
  logic [5:0]           res_gates_r;
  logic [2:0]           res_slot_r;
  logic [TURN_BITS-1:0] res_turns_r;
  logic                 res_halted_r;

  assign s1_ready  = !valid_r || out_ready;
  assign advance   = s1_valid && s1_ready;
  assign reverse   = reverse_r;
  assign seen_set  = seen_r | (6'd1 << info.slot);
  assign turns_dec = turns_r - TURN_BITS'(1);

  always_comb begin
    inhibit_nxt  = inhibit_r;
    turns_nxt    = turns_r;
    stepped_nxt  = stepped_r;
    reverse_nxt  = reverse_r;
    drive_nxt    = drive_r;
    seen_nxt     = seen_r;
    phase_on_nxt = phase_on_r;
    pduty_nxt    = pduty_r;
    gates        = 6'd0;
    slot         = 3'd0;
    case (mode)
      MODE_TICK: begin
        if (inhibit_r != 16'd0) begin
          if (inhibit_r != HOLD_STOPPED) begin
            inhibit_nxt = inhibit_r - 16'd1;
          end
        end else begin
          slot         = info.slot;
          gates        = info.gates;
          phase_on_nxt = info.enable;
          for (int i = 0; i < PHASES; i++) begin
            if (info.lo == 2'(i)) begin
              pduty_nxt[i] = '0;
            end
            if (info.hi == 2'(i)) begin
              pduty_nxt[i] = drive_r;
            end
          end
          seen_nxt = seen_set;
          if (seen_set == ALL_SEEN && info.slot == 3'd0) begin
            seen_nxt = 6'd0;
            if (turns_r != '0) begin
              turns_nxt = turns_dec;
              if (turns_dec == '0 && stepped_r) begin
                inhibit_nxt = HOLD_STOPPED;
                for (int i = 0; i < PHASES; i++) begin
                  pduty_nxt[i] = '0;
                end
              end
            end
          end
        end
      end
      MODE_SET_DUTY: begin
        drive_nxt = duty;
      end
      MODE_SET_DIR: begin
        reverse_nxt = direction;
      end
      MODE_START_STEP: begin
        stepped_nxt = 1'b1;
        reverse_nxt = direction;
        inhibit_nxt = 16'd0;
        turns_nxt   = {turn_count, 2'b00};
        if (duty_valid) begin
          drive_nxt = duty;
        end
      end
      MODE_START_CONT: begin
        inhibit_nxt = 16'd0;
        stepped_nxt = 1'b0;
        reverse_nxt = direction;
        if (duty_valid) begin
          drive_nxt = duty;
        end else begin
          phase_on_nxt = ALL_PHASES;
        end
      end
      MODE_STOP: begin
        stepped_nxt  = 1'b1;
        inhibit_nxt  = HOLD_STOPPED;
        phase_on_nxt = 3'd0;
        for (int i = 0; i < PHASES; i++) begin
          pduty_nxt[i] = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    valid_nxt = valid_r;
    if (s1_ready) begin
      valid_nxt = s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inhibit_r  <= HOLD_STOPPED;
      turns_r    <= '0;
      stepped_r  <= 1'b1;
      reverse_r  <= 1'b0;
      drive_r    <= '0;
      seen_r     <= 6'd0;
      phase_on_r <= 3'd0;
      for (int i = 0; i < PHASES; i++) begin
        pduty_r[i] <= '0;
      end
      valid_r    <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      if (advance) begin
        inhibit_r  <= inhibit_nxt;
        turns_r    <= turns_nxt;
        stepped_r  <= stepped_nxt;
        reverse_r  <= reverse_nxt;
        drive_r    <= drive_nxt;
        seen_r     <= seen_nxt;
        phase_on_r <= phase_on_nxt;
        pduty_r    <= pduty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_enable_r <= phase_on_nxt;
      res_duty_r   <= pduty_nxt;
      res_gates_r  <= gates;
      res_slot_r   <= slot;
      res_turns_r  <= turns_nxt;
      res_halted_r <= (inhibit_nxt != 16'd0);
    end
  end

  assign out_valid        = valid_r;
  assign out_phase_enable = res_enable_r;
  assign out_duty_a       = res_duty_r[0];
  assign out_duty_b       = res_duty_r[1];
  assign out_duty_c       = res_duty_r[2];
  assign out_gate_pattern = res_gates_r;
  assign out_sector       = res_slot_r;
  assign out_turns_left   = res_turns_r;
  assign out_halted       = res_halted_r;

endmodule

`default_nettype wire
